// File: rtl/b64e_pkg.sv
// Package for the base64 stream encoder: item and job types, alphabet lookup.
// No dependencies; imported by every other file of the block.
`default_nettype none

package b64e_pkg;

    // Padding character '=' and default depth of the job queue.
    localparam logic [7:0] PAD_CHAR          = 8'h3D;
    localparam int         QUEUE_DEPTH_DEF   = 4;
    localparam int         CHARS_PER_JOB     = 4;

    // One input byte with its end-of-payload flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    // One output character with its end-of-encoding flag.
    typedef struct packed {
        logic [7:0] out_char;
        logic       final_char;
    } t_out_item;

    // Position within the current three-byte group.
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    // Characters that one input byte produces, ready for emission.
    typedef struct packed {
        logic [CHARS_PER_JOB-1:0][7:0] chars;
        logic [1:0]                    last_idx;
        logic                          fin;
    } t_job;

    // Maps a sextet onto the standard alphabet with '+' and '/'.
    function automatic logic [7:0] b64_char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26) begin
            c = 8'({2'b00, s}) + 8'h41;
        end else if (s < 6'd52) begin
            c = 8'({2'b00, s}) + 8'h47;
        end else if (s < 6'd62) begin
            c = 8'({2'b00, s}) - 8'h04;
        end else if (s == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/base64_stream_encoder.sv
// Top level of the streaming base64 encoder (standard alphabet, '=' padding).
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
//   Channel   Handshake              Payload
//   input     push / full            i_data   (t_in_item: data_byte, final_byte)
//   result    pop / empty            o_result (t_out_item: out_char, final_char)
//
// A byte is taken whenever the job queue has room; its characters leave
// through the back end's output register. The back end emits one character per
// cycle while the result port takes them; a byte yields one to four characters
// (four thirds on average), so that port sets the sustained rate. Synchronous
// reset clears the group phase, the queue and the output. A stalled result
// holds the back end while the queue's QUEUE_DEPTH jobs absorb bytes.
`default_nettype none

module base64_stream_encoder
    import b64e_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_item i_data,
    input  wire logic     pop,
    output logic          empty,
    output t_out_item     o_result
);

    t_job front_job;
    t_job queue_job;
    logic take;
    logic queue_valid;
    logic queue_rd;

    assign take = push && !full;

    // Classifies each byte into a job of characters.
    b64e_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (take),
        .i_item (i_data),
        .o_job  (front_job)
    );

    // Decouples byte intake from character output.
    b64e_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (take),
        .i_wr_job(front_job),
        .o_full  (full),
        .i_rd    (queue_rd),
        .o_rd_job(queue_job),
        .o_valid (queue_valid)
    );

    // Emits characters one per cycle while the result slot is free.
    b64e_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(queue_valid),
        .i_job      (queue_job),
        .o_job_take (queue_rd),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire

// File: rtl/b64e_front.sv
// Front end of the base64 encoder: tracks the group phase and turns each
// byte into a job of one to four characters. Depends on b64e_pkg.
`default_nettype none

module b64e_front
    import b64e_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_take,
    input  wire t_in_item i_item,
    output t_job          o_job
);

    t_phase     r_phase;
    t_phase     n_phase;
    logic [3:0] r_leftover;
    logic [3:0] n_leftover;
    logic [7:0] b;
    logic       fin;

    assign b   = i_item.data_byte;
    assign fin = i_item.final_byte;

    // Next phase and leftover bits after this byte.
    always_comb begin
        n_phase    = r_phase;
        n_leftover = r_leftover;
        case (r_phase)
            PH_SECOND: begin
                n_phase    = PH_THIRD;
                n_leftover = b[3:0];
            end
            PH_THIRD: begin
                n_phase    = PH_FIRST;
                n_leftover = 4'd0;
            end
            default: begin
                n_phase    = PH_SECOND;
                n_leftover = {2'b00, b[1:0]};
            end
        endcase
        // The last byte of a payload always closes the group.
        if (fin) begin
            n_phase    = PH_FIRST;
            n_leftover = 4'd0;
        end
    end

    // Characters that this byte completes, with padding when the last byte ends a partial group.
    always_comb begin
        o_job.chars    = '0;
        o_job.last_idx = 2'd0;
        o_job.fin      = fin;
        case (r_phase)
            PH_SECOND: begin
                o_job.chars[0] = b64_char({r_leftover[1:0], b[7:4]});
                if (fin) begin
                    o_job.chars[1] = b64_char({b[3:0], 2'b00});
                    o_job.chars[2] = PAD_CHAR;
                    o_job.last_idx = 2'd2;
                end
            end
            PH_THIRD: begin
                o_job.chars[0] = b64_char({r_leftover, b[7:6]});
                o_job.chars[1] = b64_char(b[5:0]);
                o_job.last_idx = 2'd1;
            end
            default: begin
                o_job.chars[0] = b64_char(b[7:2]);
                if (fin) begin
                    o_job.chars[1] = b64_char({b[1:0], 4'b0000});
                    o_job.chars[2] = PAD_CHAR;
                    o_job.chars[3] = PAD_CHAR;
                    o_job.last_idx = 2'd3;
                end
            end
        endcase
    end

    // Phase state advances on every transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FIRST;
            r_leftover <= 4'd0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_leftover <= n_leftover;
        end
    end

endmodule

`default_nettype wire

// File: rtl/b64e_queue.sv
// Short job queue between the front end and the back end of the encoder.
// Depends on b64e_pkg for the job type.
`default_nettype none

module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_job i_wr_job,
    output logic      o_full,
    input  wire logic i_rd,
    output t_job      o_rd_job,
    output logic      o_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    t_job          r_head;
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr_en;
    logic          rd_en;
    logic          head_free;
    logic          mem_any;
    logic          load_mem;
    logic          bypass;
    logic          mem_wr;

    // The oldest job sits in a head register; later ones wait in the memory.
    assign o_full    = (r_count == CW'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && o_valid;
    assign head_free = !o_valid || rd_en;
    assign mem_any   = (r_count > CW'(1));
    assign load_mem  = head_free && mem_any;
    assign bypass    = head_free && !mem_any && wr_en;
    assign mem_wr    = wr_en && !bypass;
    assign o_rd_job  = r_head;

    // Storage for queued jobs behind the head.
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    // Head register: refilled from the memory, or straight from the input when
    // the memory holds nothing.
    always_ff @(posedge i_clk) begin
        if (load_mem) begin
            r_head <= r_mem[r_rd_ptr];
        end else if (bypass) begin
            r_head <= i_wr_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (mem_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (load_mem) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/b64e_back.sv
// Back end of the base64 encoder: takes jobs from the queue and emits their
// characters one per cycle into a free output register. Depends on b64e_pkg.
`default_nettype none

module b64e_back
    import b64e_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_job_take,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_out_item o_result
);

    t_job       r_job;
    logic       r_busy;
    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       slot_free;
    logic       at_last;
    logic       emit;

    assign slot_free  = !r_out_valid || i_pop;
    assign at_last    = (r_idx == r_job.last_idx);
    assign emit       = r_busy && slot_free;
    assign o_job_take = i_job_valid && (!r_busy || (emit && at_last));
    assign o_empty    = !r_out_valid;
    assign o_result   = r_out;

    // Current job and character index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_job_take) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (emit) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_job <= i_job;
        end
    end

    // Output register: holds a character until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.out_char   <= r_job.chars[r_idx];
            r_out.final_char <= r_job.fin && at_last;
        end
    end

endmodule

`default_nettype wire

// File: dv/base64_stream_encoder_tb.sv
// Self-checking testbench for base64_stream_encoder: byte payloads go in over push/full,
// and each character taken over pop/empty is checked against a built-in encoder model.
// Depends on b64e_pkg and the RTL of the block.
`default_nettype none

module base64_stream_encoder_tb;
    import b64e_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 20;

    // Tracks the encoder's group position and predicts the characters that each byte yields.
    class b64_char_scoreboard;
        string      alphabet;
        t_phase     phase;
        logic [3:0] carry;
        t_out_item  chars_due[$];
        int         mismatch_count;

        function new();
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            phase = PH_FIRST;
            carry = '0;
            mismatch_count = 0;
        endfunction

        function void due_char(logic [7:0] c, logic last);
            t_out_item e;
            e.out_char = c;
            e.final_char = last;
            chars_due = {chars_due, e};
        endfunction

        function logic [7:0] sextet_char(logic [5:0] s);
            return alphabet[s];
        endfunction

        // Notes one accepted byte transfer and queues the characters that it completes.
        function void encode_byte(t_in_item it);
            logic [7:0] b;
            logic       fin;
            b = it.data_byte;
            fin = it.final_byte;
            case (phase)
                PH_SECOND: begin
                    due_char(sextet_char({carry[1:0], b[7:4]}), 1'b0);
                    if (fin) begin
                        due_char(sextet_char({b[3:0], 2'b00}), 1'b0);
                        due_char(PAD_CHAR, 1'b1);
                    end else begin
                        carry = b[3:0];
                        phase = PH_THIRD;
                    end
                end
                PH_THIRD: begin
                    due_char(sextet_char({carry, b[7:6]}), 1'b0);
                    due_char(sextet_char(b[5:0]), fin);
                    carry = '0;
                    phase = PH_FIRST;
                end
                default: begin
                    due_char(sextet_char(b[7:2]), 1'b0);
                    if (fin) begin
                        due_char(sextet_char({b[1:0], 4'b0000}), 1'b0);
                        due_char(PAD_CHAR, 1'b0);
                        due_char(PAD_CHAR, 1'b1);
                    end else begin
                        carry = {2'b00, b[1:0]};
                        phase = PH_SECOND;
                    end
                end
            endcase
            // The end of a payload always starts a fresh group.
            if (fin) begin
                phase = PH_FIRST;
                carry = '0;
            end
        endfunction

        // Compares one accepted character transfer with the oldest prediction.
        function void compare_char(t_out_item got);
            t_out_item e;
            if (chars_due.size() == 0) begin
                $display("%0t: unexpected char: expected none, actual %h/%b",
                         $time, got.out_char, got.final_char);
                mismatch_count++;
            end else begin
                e = chars_due.pop_front();
                if (got.out_char !== e.out_char) begin
                    $display("%0t: out_char mismatch: expected %h, actual %h",
                             $time, e.out_char, got.out_char);
                    mismatch_count++;
                end
                if (got.final_char !== e.final_char) begin
                    $display("%0t: final_char mismatch: expected %b, actual %b",
                             $time, e.final_char, got.final_char);
                    mismatch_count++;
                end
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  i_data = '0;
    logic      pop = 1'b0;
    logic      empty;
    t_out_item o_result;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int bytes_sent = 0;
    int cycle_count = 0;

    b64_char_scoreboard sb = new();

    base64_stream_encoder u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_data   (i_data),
        .pop      (pop),
        .empty    (empty),
        .o_result (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Both transfers are observed at the rising edge, before the block updates.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                sb.encode_byte(i_data);
            end
            if (pop && !empty) begin
                sb.compare_char(o_result);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted down here.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                pop <= 1'b0;
                hold_cycles--;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offers one byte, with random gaps ahead of it, until the block takes it.
    // Entered and left at a falling edge; push stays high on return.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_data <= '{data_byte: b, final_byte: fin};
        do begin
            @(posedge i_clk);
        end while (full);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_payload(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(255)), i == len - 1);
        end
    endtask

    // Drops push and waits until every predicted character has been taken.
    task automatic wait_drained();
        push <= 1'b0;
        while (sb.chars_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Random payloads, mostly short with an occasional longer one.
    task automatic run_random(input int nbytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < nbytes) begin
            send_payload(($urandom_range(9) == 0) ? $urandom_range(16, 7)
                                                  : $urandom_range(6, 1));
        end
        wait_drained();
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 31;
        recv_idle_pct = 83;

        // Payloads ending at the first and second group position, with all-zero and all-one bytes.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // This group encodes to the '+' character four times.
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        // Two full groups: the '/' character four times, then a plain text group.
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b1);
        wait_drained();

        // Receiver holds off while bytes keep coming, so the block fills and stalls input.
        hold_cycles = HOLD_CYCLES;
        send_payload(24);
        wait_drained();

        run_random(30);

        send_idle_pct = 83;
        recv_idle_pct = 31;
        run_random(35);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(35);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.chars_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder.sv
dv/base64_stream_encoder_tb.sv
